// ----- rtl/kmc_pkg.sv -----
// Shared types and constants of the Karger minimum-cut contraction block.
`timescale 1ns / 1ps
package kmc_pkg;

   localparam int NODE_W   = 11;
   localparam int COUNT_W  = 12;
   localparam int CUT_W    = 13;
   localparam int TRIAL_W  = 16;
   localparam int SEED_W   = 32;
   localparam int PROD_W   = 21;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [SEED_W-1:0] PICK_MASK = 32'hD000_0001;
   localparam int DIV_STEPS_W = 6;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_NODES  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CUT_TARGET = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LFSR_SEED  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_TRIALS = 2'd3;

   typedef struct packed {
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic              last_edge;
   } req_type;

   typedef struct packed {
      logic [CUT_W-1:0]   cut_edges;
      logic [COUNT_W-1:0] side_one_size;
      logic [COUNT_W-1:0] side_two_size;
      logic [PROD_W-1:0]  size_product;
      logic [TRIAL_W-1:0] trials_used;
      logic               found;
   } rsp_type;

   typedef struct packed {
      logic load_edge;
      logic seed;
      logic trial_init;
      logic lbl_init;
      logic cross_clr;
      logic lbl_rd_edge;
      logic cross_acc;
      logic lfsr_step;
      logic div_step;
      logic pick_rd;
      logic pick_cap;
      logic node_clr;
      logic node_wr;
      logic merge_done;
      logic trial_end;
      logic root_rd;
      logic side_clr;
      logic side_acc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic node_done;
      logic edge_done;
      logic div_done;
      logic pick_ok;
      logic trial_go;
      logic accept;
      logic limit_hit;
   } sts_type;

endpackage

// ----- rtl/kmc_ctrl.sv -----
// Sequencing state machine of the Karger contraction block.
`timescale 1ns / 1ps
module kmc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             last_edge,
   input  kmc_pkg::sts_type sts,
   output kmc_pkg::cmd_type cmd,
   output logic             busy
);
   import kmc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SEED, ST_LINIT, ST_ERD, ST_ELBL, ST_EACC, ST_DECIDE, ST_DIV,
      ST_PLBL, ST_PCAP, ST_NRD, ST_NWR, ST_TCHECK, ST_ROOT, ST_SRD, ST_SACC,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_edge = 1'b1;
               if (last_edge) state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.seed       = 1'b1;
            cmd.trial_init = 1'b1;
            state_in       = ST_LINIT;
         end
         ST_LINIT: begin
            if (sts.node_done) begin
               cmd.cross_clr = 1'b1;
               state_in      = ST_ERD;
            end else begin
               cmd.lbl_init = 1'b1;
            end
         end
         ST_ERD:  state_in = sts.edge_done ? ST_DECIDE : ST_ELBL;
         ST_ELBL: begin
            cmd.lbl_rd_edge = 1'b1;
            state_in        = ST_EACC;
         end
         ST_EACC: begin
            cmd.cross_acc = 1'b1;
            state_in      = ST_ERD;
         end
         ST_DECIDE: begin
            if (sts.trial_go) begin
               cmd.lfsr_step = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.trial_end = 1'b1;
               state_in      = ST_TCHECK;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.pick_rd = 1'b1;
               state_in    = ST_PLBL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_PLBL: begin
            cmd.lbl_rd_edge = 1'b1;
            state_in        = ST_PCAP;
         end
         ST_PCAP: begin
            if (sts.pick_ok) begin
               cmd.pick_cap = 1'b1;
               cmd.node_clr = 1'b1;
               state_in     = ST_NRD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_NRD: begin
            if (sts.node_done) begin
               cmd.merge_done = 1'b1;
               cmd.cross_clr  = 1'b1;
               state_in       = ST_ERD;
            end else begin
               state_in = ST_NWR;
            end
         end
         ST_NWR: begin
            cmd.node_wr = 1'b1;
            state_in    = ST_NRD;
         end
         ST_TCHECK: begin
            if (sts.accept || sts.limit_hit) begin
               cmd.root_rd = 1'b1;
               state_in    = ST_ROOT;
            end else begin
               cmd.trial_init = 1'b1;
               state_in       = ST_LINIT;
            end
         end
         ST_ROOT: begin
            cmd.side_clr = 1'b1;
            state_in     = ST_SRD;
         end
         ST_SRD:  state_in = sts.node_done ? ST_EMIT : ST_SACC;
         ST_SACC: begin
            cmd.side_acc = 1'b1;
            state_in     = ST_SRD;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ----- rtl/kmc_datapath.sv -----
// Edge store, label store, counters, edge picker and modulo unit.
`timescale 1ns / 1ps
module kmc_datapath #(
   parameter int MAX_NODES = 2048,
   parameter int MAX_EDGES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [kmc_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [kmc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  kmc_pkg::req_type                     req_data,
   input  kmc_pkg::cmd_type                     cmd,
   output kmc_pkg::sts_type                     sts,
   output logic                                 rsp_valid,
   output kmc_pkg::rsp_type                     rsp_data
);
   import kmc_pkg::*;

   localparam int LW  = $clog2(MAX_NODES);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W = 2 * NODE_W;

   // configuration
   logic [COUNT_W-1:0] num_nodes_ff;
   logic [CUT_W-1:0]   cut_target_ff;
   logic [SEED_W-1:0]  lfsr_seed_ff;
   logic [TRIAL_W-1:0] max_trials_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff  <= COUNT_W'(2);
         cut_target_ff <= CUT_W'(3);
         lfsr_seed_ff  <= SEED_W'(1);
         max_trials_ff <= TRIAL_W'(1024);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NUM_NODES:  num_nodes_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_CUT_TARGET: cut_target_ff <= csr_wdata[CUT_W-1:0];
            CSR_LFSR_SEED:  lfsr_seed_ff  <= csr_wdata[SEED_W-1:0];
            CSR_MAX_TRIALS: max_trials_ff <= csr_wdata[TRIAL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [COUNT_W-1:0] n_act;
   logic [TRIAL_W-1:0] limit;
   always_comb begin
      if (num_nodes_ff < COUNT_W'(2))        n_act = COUNT_W'(2);
      else if (32'(num_nodes_ff) > MAX_NODES) n_act = COUNT_W'(MAX_NODES);
      else                                    n_act = num_nodes_ff;
      limit = (max_trials_ff == '0) ? TRIAL_W'(1) : max_trials_ff;
   end

   // edge store
   logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0] edge_q_ff;
   logic [EW-1:0]     total_ff;
   logic [EW-1:0]     e_ff;
   logic [EW-1:0]     rem_ff;
   logic [EAW-1:0]    edge_raddr;

   assign edge_raddr = cmd.pick_rd ? rem_ff[EAW-1:0] : e_ff[EAW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_edge && (total_ff < EW'(MAX_EDGES)))
         edge_mem[total_ff[EAW-1:0]] <= {req_data.node_b, req_data.node_a};
      edge_q_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.emit) begin
         total_ff <= '0;
      end else if (cmd.load_edge && (total_ff < EW'(MAX_EDGES))) begin
         total_ff <= total_ff + EW'(1);
      end
   end

   logic [NODE_W-1:0] ea, eb;
   logic              e_live;
   assign ea     = edge_q_ff[NODE_W-1:0];
   assign eb     = edge_q_ff[EDGE_W-1:NODE_W];
   assign e_live = (COUNT_W'(ea) < n_act) && (COUNT_W'(eb) < n_act);

   // label store: one write port, two registered read ports
   logic [LW-1:0]      label_mem [MAX_NODES];
   logic [LW-1:0]      rd_a_ff, rd_b_ff;
   logic [LW-1:0]      raddr_a, raddr_b, waddr, wdata;
   logic               we;
   logic [COUNT_W-1:0] i_ff;
   logic [LW-1:0]      la_ff, lb_ff, lo, root_ff;
   logic               live_ff;

   assign lo = (la_ff < lb_ff) ? la_ff : lb_ff;

   always_comb begin
      if (cmd.root_rd)          raddr_a = '0;
      else if (cmd.lbl_rd_edge) raddr_a = LW'(ea);
      else                      raddr_a = LW'(i_ff);
      raddr_b = LW'(eb);
      waddr   = LW'(i_ff);
      if (cmd.lbl_init) begin
         we    = 1'b1;
         wdata = LW'(i_ff);
      end else begin
         we    = cmd.node_wr && ((rd_a_ff == la_ff) || (rd_a_ff == lb_ff));
         wdata = lo;
      end
   end

   always_ff @(posedge clock) begin
      if (we) label_mem[waddr] <= wdata;
      rd_a_ff <= label_mem[raddr_a];
      rd_b_ff <= label_mem[raddr_b];
   end

   // counters
   logic [COUNT_W-1:0] groups_ff, side1_ff;
   logic [EW-1:0]      cross_ff;
   logic [TRIAL_W-1:0] trials_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff      <= '0;
         e_ff      <= '0;
         groups_ff <= COUNT_W'(2);
         cross_ff  <= '0;
         trials_ff <= '0;
         side1_ff  <= '0;
      end else begin
         if (cmd.trial_init || cmd.node_clr || cmd.side_clr) i_ff <= '0;
         else if (cmd.lbl_init || cmd.node_wr || cmd.side_acc) i_ff <= i_ff + COUNT_W'(1);
         if (cmd.cross_clr) begin
            e_ff     <= '0;
            cross_ff <= '0;
         end else if (cmd.cross_acc) begin
            e_ff <= e_ff + EW'(1);
            if (live_ff && (rd_a_ff != rd_b_ff)) cross_ff <= cross_ff + EW'(1);
         end
         if (cmd.trial_init)      groups_ff <= n_act;
         else if (cmd.merge_done) groups_ff <= groups_ff - COUNT_W'(1);
         if (cmd.seed)           trials_ff <= '0;
         else if (cmd.trial_end) trials_ff <= trials_ff + TRIAL_W'(1);
         if (cmd.side_clr) side1_ff <= '0;
         else if (cmd.side_acc && (rd_a_ff == root_ff)) side1_ff <= side1_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lbl_rd_edge) live_ff <= e_live;
      if (cmd.pick_cap) begin
         la_ff <= rd_a_ff;
         lb_ff <= rd_b_ff;
      end
      if (cmd.side_clr) root_ff <= rd_a_ff;
   end

   // edge picker and bit-serial modulo by the edge count
   logic [SEED_W-1:0]      lfsr_ff, lfsr_next, quo_ff;
   logic [DIV_STEPS_W-1:0] div_cnt_ff;
   logic [EW:0]            rem_sh;

   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? PICK_MASK : '0);
   assign rem_sh    = {rem_ff, quo_ff[SEED_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff    <= SEED_W'(1);
         div_cnt_ff <= '0;
      end else begin
         if (cmd.seed) lfsr_ff <= (lfsr_seed_ff == '0) ? SEED_W'(1) : lfsr_seed_ff;
         else if (cmd.lfsr_step) lfsr_ff <= lfsr_next;
         if (cmd.lfsr_step)     div_cnt_ff <= '0;
         else if (cmd.div_step) div_cnt_ff <= div_cnt_ff + DIV_STEPS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lfsr_step) begin
         quo_ff <= lfsr_next;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SEED_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, total_ff}) rem_ff <= EW'(rem_sh - {1'b0, total_ff});
         else                            rem_ff <= rem_sh[EW-1:0];
      end
   end

   // status
   always_comb begin
      sts.node_done = (i_ff == n_act);
      sts.edge_done = (e_ff == total_ff);
      sts.div_done  = (div_cnt_ff == DIV_STEPS_W'(SEED_W));
      sts.pick_ok   = live_ff && (rd_a_ff != rd_b_ff);
      sts.trial_go  = (groups_ff > COUNT_W'(2)) && (cross_ff != '0);
      sts.accept    = (32'(cross_ff) <= 32'(cut_target_ff));
      sts.limit_hit = (trials_ff >= limit);
   end

   // result register
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic [COUNT_W-1:0] side2;
   logic [2*COUNT_W-1:0] prod;
   assign side2 = n_act - side1_ff;
   assign prod  = side1_ff * side2;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.emit;
      if (cmd.emit) begin
         rsp_ff.cut_edges     <= CUT_W'(cross_ff);
         rsp_ff.side_one_size <= side1_ff;
         rsp_ff.side_two_size <= side2;
         rsp_ff.size_product  <= prod[PROD_W-1:0];
         rsp_ff.trials_used   <= trials_ff;
         rsp_ff.found         <= sts.accept;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/karger_min_cut_contraction.sv -----
// Top level of the Karger randomised minimum-cut contraction block.
// Loading: one edge transaction per cycle while busy is low; a plain edge gives no result.
// Search: after the last edge, each trial relabels the nodes and counts the crossing edges,
//   then per pick runs the modulo unit (one remainder bit a cycle) and, on a merge,
//   relabels the nodes and recounts; the edge and label memory ports set the pace.
// The result strobe is registered in the cycle after the emit state and cannot be held off.
// Reset: synchronous, active high; clears the edge count and restores register defaults.
`timescale 1ns / 1ps
module karger_min_cut_contraction #(
   parameter int MAX_NODES = 2048,
   parameter int MAX_EDGES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  kmc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output kmc_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [kmc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [kmc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import kmc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence the trials
   kmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_edge (req_data.last_edge),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   // hold edges and labels, count and pick
   kmc_datapath #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result transaction only ever closes a search
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a search");

   // node 0 always lies on side one
   a_side_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.side_one_size != '0))
      else $error("empty side one");

   // at least one trial runs
   a_trials: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.trials_used != '0))
      else $error("no trial counted");

endmodule
